FILE: design/bmf_pkg.sv
// ---------------------------------------------------------------------------
// bmf_pkg
// Shared types and constants of the box mean filter: item formats, the
// queued operation handed from the front end to the back end, and the
// effective configuration.
// ---------------------------------------------------------------------------
package bmf_pkg;

	// Rows per frame are capped at this value.
	localparam logic [10:0] MAX_HEIGHT = 11'd1024;

	// Field widths sized for the full legal parameter range
	// (line width up to 4096, radius up to 7).
	localparam int COL_W  = 13;
	localparam int ROW_W  = 11;
	localparam int LROW_W = 5;
	localparam int OFF_W  = 4;
	localparam int RAD_W  = 3;
	localparam int POS_W  = 24;
	localparam int SUM_W  = 16;
	localparam int CNT_W  = 8;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic [7:0] pixel;
		logic       drain;
	} in_item_t;

	typedef struct packed {
		logic [7:0] filtered_pixel;
		logic       frame_last;
	} out_item_t;

	typedef struct packed {
		logic [COL_W-1:0] w;
		logic [ROW_W-1:0] h;
		logic [RAD_W-1:0] r;
	} cfg_t;

	typedef struct packed {
		logic              wr_en;
		logic [LROW_W-1:0] wr_row;
		logic [COL_W-1:0]  wr_col;
		logic [7:0]        wr_data;
		logic              has_out;
		logic [ROW_W-1:0]  out_row;
		logic [LROW_W-1:0] out_rmod;
		logic [COL_W-1:0]  out_col;
		logic              last;
	} op_t;

endpackage

FILE: design/box_mean_filter.sv
// ---------------------------------------------------------------------------
// box_mean_filter
// Streaming 2-D box mean filter for 8-bit grey pixels in raster order.
// ---------------------------------------------------------------------------
// Usage: pixels enter on the in channel in raster order, one request per
// pixel. After the last pixel of a frame the host sends drain requests,
// which carry no pixel and only advance the position, until the output
// marked frame_last has appeared. Each output is the truncated mean of the
// in-image pixels of the (2r+1)x(2r+1) window and lags its input by r rows
// plus r pixels. The cfg channel writes image width, height and radius by
// index; it is always ready and must only be used while the block is idle.
// Flow: a request enters a two-entry operation queue. The back end pops
// one operation per visit of its idle state. A request that yields no
// output is done there; one that yields an output keeps the back end busy
// while it sums the window through the single read port of the line store
// (one window pixel per cycle) and runs the 16-step bit-serial divider.
// The result sits in an output register; while the receiver stalls it is
// held, the back end waits and the queue keeps taking up to two requests.
// Reset clears all positions and control state and loads the register
// defaults 640 x 480, radius 1. The line store is not cleared.
// ---------------------------------------------------------------------------
module box_mean_filter import bmf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	logic [10:0] width_q, height_q;
	logic [1:0]  radius_q;
	cfg_t        cfg;

	logic q_push_valid, q_push_ready, q_valid, q_ready;
	op_t  q_push_op, q_op;

	// The configuration port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 11'd480;
			radius_q <= 2'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective settings: zero sizes act as one, width and radius are capped at
	// what the line store can hold and height is capped at MAX_HEIGHT.
	always_comb begin
		if (width_q == 11'd0)
			cfg.w = COL_W'(1);
		else if (COL_W'(width_q) > COL_W'(MAX_WIDTH))
			cfg.w = COL_W'(MAX_WIDTH);
		else
			cfg.w = COL_W'(width_q);
		if (height_q == 11'd0)
			cfg.h = ROW_W'(1);
		else if (height_q > MAX_HEIGHT)
			cfg.h = ROW_W'(MAX_HEIGHT);
		else
			cfg.h = ROW_W'(height_q);
		cfg.r = (RAD_W'(radius_q) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) :
			RAD_W'(radius_q);
	end

	bmf_front #(
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.op_valid (q_push_valid),
		.op_ready (q_push_ready),
		.op       (q_push_op)
	);

	bmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_op    (q_push_op),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_op     (q_op)
	);

	bmf_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.op_valid  (q_valid),
		.op_ready  (q_ready),
		.op        (q_op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// The back end only takes a new operation once its result register is empty.
	a_pop_needs_empty_out: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready |-> !out_valid)
		else $error("back end popped while a result was pending");

	// Queued output jobs always point inside the current line.
	a_out_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_op.has_out |-> q_op.out_col < cfg.w)
		else $error("output column outside the image line");

	// Queued line store writes always land inside the current line.
	a_wr_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_op.wr_en |-> q_op.wr_col < cfg.w)
		else $error("line store write outside the image line");

endmodule

FILE: design/bmf_front.sv
// ---------------------------------------------------------------------------
// bmf_front
// Accepts input items, tracks the input and output raster positions and
// turns each item into an optional line store write and output job.
// ---------------------------------------------------------------------------
module bmf_front import bmf_pkg::*; #(
	parameter int MAX_RADIUS = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     op_valid,
	input  logic     op_ready,
	output op_t      op
);

	localparam int LINE_ROWS = 3 * MAX_RADIUS + 1;

	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [LROW_W-1:0] in_rmod_q, out_rmod_q;

	logic              clr;
	logic [COL_W-1:0]  c_ic, c_oc, n_ic, n_oc;
	logic [ROW_W-1:0]  c_ir, c_or, n_ir, n_or;
	logic [LROW_W-1:0] c_irm, c_orm, n_irm, n_orm;
	logic [POS_W-1:0]  c_pos, lag;
	logic              has_out, last, accept;

	assign in_ready = op_ready;
	assign op_valid = in_valid;
	assign accept   = in_valid && op_ready;

	always_comb begin
		// A position left out of range by a configuration change restarts the frame.
		clr = (in_col_q >= cfg.w) || (out_col_q >= cfg.w) || (out_row_q >= cfg.h) ||
			({1'b0, in_row_q} > ({1'b0, cfg.h} + (ROW_W+1)'(2 * MAX_RADIUS + 1)));
		c_ic  = clr ? '0 : in_col_q;
		c_ir  = clr ? '0 : in_row_q;
		c_irm = clr ? '0 : in_rmod_q;
		c_oc  = clr ? '0 : out_col_q;
		c_or  = clr ? '0 : out_row_q;
		c_orm = clr ? '0 : out_rmod_q;

		// Linear input position within the frame under the current width.
		c_pos   = POS_W'(c_ir) * POS_W'(cfg.w) + POS_W'(c_ic);
		lag     = POS_W'(cfg.r) * POS_W'(cfg.w) + POS_W'(cfg.r);
		has_out = (c_pos >= lag);
		last    = (c_or == cfg.h - ROW_W'(1)) && (c_oc == cfg.w - COL_W'(1));

		op.wr_en    = (c_ir < cfg.h);
		op.wr_row   = c_irm;
		op.wr_col   = c_ic;
		op.wr_data  = in_data.drain ? 8'd0 : in_data.pixel;
		op.has_out  = has_out;
		op.out_row  = c_or;
		op.out_rmod = c_orm;
		op.out_col  = c_oc;
		op.last     = last;

		n_ic  = c_ic + COL_W'(1);
		n_ir  = c_ir;
		n_irm = c_irm;
		if (n_ic >= cfg.w) begin
			n_ic  = '0;
			n_ir  = c_ir + ROW_W'(1);
			n_irm = (c_irm == LROW_W'(LINE_ROWS - 1)) ? '0 : c_irm + LROW_W'(1);
		end

		n_oc  = c_oc;
		n_or  = c_or;
		n_orm = c_orm;
		if (has_out) begin
			n_oc = c_oc + COL_W'(1);
			if (n_oc >= cfg.w) begin
				n_oc  = '0;
				n_or  = c_or + ROW_W'(1);
				n_orm = (c_orm == LROW_W'(LINE_ROWS - 1)) ? '0 : c_orm + LROW_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_rmod_q  <= '0;
			out_col_q  <= '0;
			out_row_q  <= '0;
			out_rmod_q <= '0;
		end else if (accept) begin
			if (has_out && last) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				in_rmod_q  <= '0;
				out_col_q  <= '0;
				out_row_q  <= '0;
				out_rmod_q <= '0;
			end else begin
				in_col_q   <= n_ic;
				in_row_q   <= n_ir;
				in_rmod_q  <= n_irm;
				out_col_q  <= n_oc;
				out_row_q  <= n_or;
				out_rmod_q <= n_orm;
			end
		end
	end

endmodule

FILE: design/bmf_queue.sv
// ---------------------------------------------------------------------------
// bmf_queue
// Two-entry queue of operations between the front end and the back end.
// ---------------------------------------------------------------------------
module bmf_queue import bmf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	op_t  entry_q [2];
	logic rd_ptr_q, wr_ptr_q;
	logic [1:0] count_q;
	logic push, pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: design/bmf_back.sv
// ---------------------------------------------------------------------------
// bmf_back
// Executes queued operations: writes the line store, sums the in-image
// window one line store read per cycle, divides by the pixel count with a
// bit-serial divider and holds the result until it is taken.
// ---------------------------------------------------------------------------
module bmf_back import bmf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      op_valid,
	output logic      op_ready,
	input  op_t       op,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int LINE_ROWS = 3 * MAX_RADIUS + 1;
	localparam int LR_W      = $clog2(LINE_ROWS);
	localparam int CA_W      = $clog2(MAX_WIDTH);
	localparam int STEP_W    = $clog2(SUM_W);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SUM  = 3'd1;
	localparam logic [2:0] ST_FIN  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [7:0] mem [LINE_ROWS][MAX_WIDTH];

	logic [2:0]        state_q;
	logic [ROW_W-1:0]  orow_q;
	logic [LROW_W-1:0] ormod_q;
	logic [COL_W-1:0]  ocol_q;
	logic              last_q;
	logic [OFF_W-1:0]  dk_q, dl_q;
	logic [SUM_W-1:0]  sum_q, quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W:0]    rem_q;
	logic [STEP_W-1:0] step_q;
	logic              rd_v_q;
	logic [7:0]        rd_data_q;

	logic [ROW_W:0]    y_ext, y_rel;
	logic [COL_W:0]    x_ext, x_rel;
	logic [LROW_W:0]   rrow_base, rrow_wrap, rrow_sum, rrow;
	logic              inb;
	logic [OFF_W-1:0]  span;
	logic [SUM_W-1:0]  sum_add;
	logic [CNT_W:0]    shifted;

	always_comb begin
		span  = OFF_W'({cfg.r, 1'b0});
		y_ext = {1'b0, orow_q} + (ROW_W+1)'(dk_q);
		y_rel = y_ext - (ROW_W+1)'(cfg.r);
		x_ext = {1'b0, ocol_q} + (COL_W+1)'(dl_q);
		x_rel = x_ext - (COL_W+1)'(cfg.r);
		inb   = (y_ext >= (ROW_W+1)'(cfg.r)) && (y_rel < {1'b0, cfg.h}) &&
			(x_ext >= (COL_W+1)'(cfg.r)) && (x_rel < {1'b0, cfg.w});
		// Top row of the window in the circular line store, then the row offset.
		rrow_base = (LROW_W+1)'(ormod_q) + (LROW_W+1)'(LINE_ROWS) - (LROW_W+1)'(cfg.r);
		rrow_wrap = (rrow_base >= (LROW_W+1)'(LINE_ROWS)) ?
			rrow_base - (LROW_W+1)'(LINE_ROWS) : rrow_base;
		rrow_sum = rrow_wrap + (LROW_W+1)'(dk_q);
		rrow = (rrow_sum >= (LROW_W+1)'(LINE_ROWS)) ?
			rrow_sum - (LROW_W+1)'(LINE_ROWS) : rrow_sum;
		sum_add = sum_q + (rd_v_q ? SUM_W'(rd_data_q) : '0);
		shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	end

	assign op_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign out_data.filtered_pixel = quo_q[7:0];
	assign out_data.frame_last     = last_q;

	always_ff @(posedge clk) begin
		if (op_valid && op_ready && op.wr_en) begin
			mem[op.wr_row[LR_W-1:0]][op.wr_col[CA_W-1:0]] <= op.wr_data;
		end
		rd_data_q <= mem[rrow[LR_W-1:0]][x_rel[CA_W-1:0]];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				orow_q  <= op.out_row;
				ormod_q <= op.out_rmod;
				ocol_q  <= op.out_col;
				last_q  <= op.last;
				dk_q    <= '0;
				dl_q    <= '0;
				sum_q   <= '0;
				cnt_q   <= '0;
			end
			ST_SUM: begin
				sum_q <= sum_add;
				if (inb) cnt_q <= cnt_q + CNT_W'(1);
				if (dl_q == span) begin
					dl_q <= '0;
					dk_q <= dk_q + OFF_W'(1);
				end else begin
					dl_q <= dl_q + OFF_W'(1);
				end
			end
			ST_FIN: begin
				quo_q  <= sum_add;
				rem_q  <= '0;
				step_q <= '0;
			end
			ST_DIV: begin
				if (shifted >= {1'b0, cnt_q}) begin
					rem_q <= shifted - {1'b0, cnt_q};
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
				step_q <= step_q + STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_q  <= 1'b0;
		end else begin
			rd_v_q <= (state_q == ST_SUM) && inb;
			unique case (state_q)
				ST_IDLE: if (op_valid && op.has_out) state_q <= ST_SUM;
				ST_SUM:  if ((dl_q == span) && (dk_q == span)) state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_DIV;
				ST_DIV:  if (step_q == STEP_W'(SUM_W - 1)) state_q <= ST_OUT;
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: test/tb_box_mean_filter.sv
// ---------------------------------------------------------------------------
// tb_box_mean_filter
// Self-checking testbench for the streaming box mean filter: a short
// directed table followed by random frames with random sizes, checked
// against a behavioral model of the window mean kept in the testbench.
// ---------------------------------------------------------------------------
module tb_box_mean_filter;
	import bmf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_ROWS   = 10;
	localparam int STORE_COLS  = 1024;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_ITEMS = 500;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;

	box_mean_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// One row of the directed table: either a register write or a pixel
	// request with the result typed in by hand.
	typedef struct {
		bit         is_write;
		logic [1:0] index;
		logic [10:0] value;
		in_item_t   item;
		bit         has_out;
		out_item_t  want;
	} directed_row_t;

	directed_row_t directed_rows[$];
	out_item_t     mean_expect_q[$];
	int            fail_count;
	int            result_count;
	int            cycle_count;
	int            sent_count;

	// Model state: register values, positions and the row buffer.
	logic [10:0] reg_width, reg_height;
	logic [1:0]  reg_radius;
	int          in_col, in_row, out_col, out_row;
	logic [7:0]  row_store [LINE_ROWS][STORE_COLS];

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int eff_width();
		if (reg_width == 0)
			return 1;
		return (reg_width > 1024) ? 1024 : int'(reg_width);
	endfunction

	function automatic int eff_height();
		if (reg_height == 0)
			return 1;
		return (reg_height > MAX_HEIGHT) ? int'(MAX_HEIGHT) : int'(reg_height);
	endfunction

	function automatic void clear_positions();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
	endfunction

	// Works out the result of one accepted request, if it yields one, and
	// advances the positions the same way the block does.
	function automatic bit predict_mean(input in_item_t item, output out_item_t res);
		int  w, h, r, pos, lag, sum, cnt, y, x;
		bit  last;
		w = eff_width();
		h = eff_height();
		r = int'(reg_radius);
		res = '0;
		if (in_col >= w || out_col >= w || out_row >= h || in_row > h + 7)
			clear_positions();
		pos = in_row * w + in_col;
		if (in_row < h)
			row_store[in_row % LINE_ROWS][in_col] = item.drain ? 8'd0 : item.pixel;
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		lag = r * w + r;
		if (pos < lag)
			return 1'b0;
		sum = 0;
		cnt = 0;
		for (int k = -r; k <= r; k++) begin
			y = out_row + k;
			if (y < 0 || y >= h)
				continue;
			for (int l = -r; l <= r; l++) begin
				x = out_col + l;
				if (x < 0 || x >= w)
					continue;
				sum += row_store[y % LINE_ROWS][x];
				cnt++;
			end
		end
		if (cnt == 0)
			cnt = 1;
		last = (out_row == h - 1) && (out_col == w - 1);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
		end
		if (last)
			clear_positions();
		res.filtered_pixel = 8'(sum / cnt);
		res.frame_last = last;
		return 1'b1;
	endfunction

	task automatic mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d (result %0d)",
			what, got, want, result_count);
		fail_count++;
	endtask

	// Waits until every expected result has come back, then lets the back
	// end settle before a register write.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (mean_expect_q.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] index, input logic [10:0] value);
		wait_idle();
		cfg_index <= index;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (index)
			REG_WIDTH:  reg_width  = value;
			REG_HEIGHT: reg_height = value;
			REG_RADIUS: reg_radius = value[1:0];
			default: ;
		endcase
	endtask

	// Offers one request after a random gap. When typed is set the given
	// expectation replaces the model's answer, though the model still runs.
	task automatic send_pixel(input in_item_t item, input bit typed,
		input bit has_out, input out_item_t want, output bit got_last);
		int        gap;
		out_item_t res;
		bit        produced;
		gap = $urandom_range(0, 19);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sent_count++;
		produced = predict_mean(item, res);
		got_last = produced && res.frame_last;
		if (typed) begin
			if (has_out)
				mean_expect_q.push_back(want);
		end else if (produced) begin
			mean_expect_q.push_back(res);
		end
	endtask

	// Sends one frame of random content under the current registers, then
	// drains until the model reports the last output of the frame.
	task automatic run_frame();
		in_item_t item;
		bit       done;
		int       h;
		h = eff_height();
		done = 1'b0;
		while (!done) begin
			item.pixel = $urandom_range(0, 255);
			case ($urandom_range(0, 7))
				0: item.pixel = 8'h00;
				1: item.pixel = 8'hFF;
				default: ;
			endcase
			if (in_row < h && !(in_col == 0 && in_row == 0 && out_row != 0))
				item.drain = ($urandom_range(0, 15) == 0);
			else
				item.drain = ($urandom_range(0, 3) != 0);
			send_pixel(item, 1'b0, 1'b0, '0, done);
		end
	endtask

	task automatic configure(input logic [10:0] w, input logic [10:0] h,
		input logic [1:0] r);
		write_register(REG_WIDTH, w);
		write_register(REG_HEIGHT, h);
		write_register(REG_RADIUS, {9'($urandom()), r});
	endtask

	function automatic void add_write(input logic [1:0] index, input logic [10:0] value);
		directed_row_t row;
		row = '{default: '0};
		row.is_write = 1'b1;
		row.index = index;
		row.value = value;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_request(input logic [7:0] pix, input logic drain,
		input bit has_out, input logic [7:0] mean, input logic last);
		directed_row_t row;
		row = '{default: '0};
		row.item.pixel = pix;
		row.item.drain = drain;
		row.has_out = has_out;
		row.want.filtered_pixel = mean;
		row.want.frame_last = last;
		directed_rows.push_back(row);
	endfunction

	// Every result that leaves the block is compared with the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (mean_expect_q.size() == 0) begin
				mismatch("unexpected result", out_data.filtered_pixel, -1);
			end else begin
				out_item_t want;
				want = mean_expect_q.pop_front();
				if (out_data.filtered_pixel !== want.filtered_pixel)
					mismatch("filtered_pixel", out_data.filtered_pixel, want.filtered_pixel);
				if (out_data.frame_last !== want.frame_last)
					mismatch("frame_last", out_data.frame_last, want.frame_last);
			end
		end
	end

	// Receiver: random stalls between results, and once a long hold-off so
	// that the operation queue fills and the input side backs up.
	initial begin
		int  gap;
		bit  held;
		out_ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 19);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			if (!held && result_count >= 40) begin
				gap = 600;
				held = 1'b1;
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("box_mean_filter verification failed");
			$finish;
		end
	end

	initial begin
		bit sent_last;
		int random_start;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data  = '0;
		arst_n    = 1'b0;
		fail_count = 0;
		result_count = 0;
		cycle_count = 0;
		sent_count = 0;
		reg_width  = 11'd640;
		reg_height = 11'd480;
		reg_radius = 2'd1;
		clear_positions();
		foreach (row_store[i, j])
			row_store[i][j] = 8'd0;

		// After reset the lag is a whole row plus one, so nothing comes out.
		add_request(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		add_request(8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
		add_request(8'hAA, 1'b1, 1'b0, 8'h00, 1'b0);
		add_request(8'h55, 1'b0, 1'b0, 8'h00, 1'b0);
		// A one-pixel frame with no window: each pixel is its own frame.
		// The width write also abandons the partial default-size frame.
		add_write(REG_WIDTH, 11'd1);
		add_write(REG_HEIGHT, 11'd1);
		add_write(REG_RADIUS, 11'd0);
		add_request(8'h00, 1'b0, 1'b1, 8'h00, 1'b1);
		add_request(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1);
		// A drain inside the frame stores zero.
		add_request(8'h55, 1'b1, 1'b1, 8'h00, 1'b1);
		// 2x2 frame with radius 1: every window covers the whole image.
		// Pixels sent after the frame act as drains and are ignored.
		add_write(REG_WIDTH, 11'd2);
		add_write(REG_HEIGHT, 11'd2);
		add_write(REG_RADIUS, 11'd1);
		add_request(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		add_request(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		add_request(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0);
		add_request(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0);
		add_request(8'h00, 1'b0, 1'b1, 8'hFF, 1'b0);
		add_request(8'h12, 1'b1, 1'b1, 8'hFF, 1'b0);
		add_request(8'h00, 1'b0, 1'b1, 8'hFF, 1'b1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write)
				write_register(directed_rows[i].index, directed_rows[i].value);
			else
				send_pixel(directed_rows[i].item, 1'b1, directed_rows[i].has_out,
					directed_rows[i].want, sent_last);
		end

		// Random frames. A few phases use long lines, tall columns and zero
		// sizes; the rest stay small so that borders and the bottom rows
		// come up often.
		random_start = sent_count;
		for (int phase = 0; (sent_count - random_start) < RANDOM_ITEMS || phase < 8;
			phase++) begin
			case (phase)
				2: configure(11'd64, 11'd1, 2'd0);
				4: configure(11'd1, 11'd40, 2'd3);
				6: configure(11'd32, 11'd2, 2'd3);
				7: configure(11'd0, 11'd0, 2'd2);
				default: configure(11'($urandom_range(0, 12)), 11'($urandom_range(0, 8)),
					2'($urandom_range(0, 3)));
			endcase
			run_frame();
		end

		wait_idle();
		if (fail_count == 0)
			$display("box_mean_filter verification clean");
		else
			$display("box_mean_filter verification failed");
		$finish;
	end

endmodule

FILE: sim.f
design/bmf_pkg.sv
design/bmf_front.sv
design/bmf_queue.sv
design/bmf_back.sv
design/box_mean_filter.sv
test/tb_box_mean_filter.sv
